// ===== hw/rtl/rptk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rptk_pkg: shared types and constants
// Item and result layouts, cell entry and cell control, register indexes and
// atom kind codes for the residue-pair contact selector.
// ----------------------------------------------------------------------------
package rptk_pkg;

  localparam int MAX_KEEP   = 8;
  localparam int ATOM_W     = 16;
  localparam int COORD_W    = 16;
  localparam int SQ_W       = 32;
  localparam int DIST_W     = 34;
  localparam int THR_W      = 24;
  localparam int KEEP_W     = 4;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_SQ     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE_COVALENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT       = 2'd2;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 24'd256000;
  localparam logic [KEEP_W-1:0] KEEP_RESET      = 4'd1;

  localparam logic [KIND_W-1:0] KIND_N  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CA = 3'd2;
  localparam logic [KIND_W-1:0] KIND_C  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_O  = 3'd4;

  typedef struct packed {
    logic [ATOM_W-1:0]         first_atom;
    logic [ATOM_W-1:0]         second_atom;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic                      adjacent_residues;
    logic [KIND_W-1:0]         first_kind;
    logic [KIND_W-1:0]         second_kind;
    logic                      last_pair;
  } in_item_t;

  typedef struct packed {
    logic [ATOM_W-1:0] out_first_atom;
    logic [ATOM_W-1:0] out_second_atom;
    logic [DIST_W-1:0] out_dist_sq;
    logic              last_of_run;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] dist_sq;
    logic [ATOM_W-1:0] first;
    logic [ATOM_W-1:0] second;
  } entry_t;

  typedef struct packed {
    logic              insert;
    logic              unload;
    logic              flush;
    logic              skip;
    logic [DIST_W-1:0] dist_sq;
    logic [ATOM_W-1:0] first;
    logic [ATOM_W-1:0] second;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rptk_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rptk_cell: one slot of the sorted contact list
// Compares the broadcast distance with its own entry, takes the new pair or
// the left neighbor's entry on insert, the right one's on unload; flush clears it.
// ----------------------------------------------------------------------------
module rptk_cell import rptk_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       in_range,
  input  wire entry_t     left_ent,
  input  wire logic       left_lt,
  input  wire entry_t     right_ent,
  output entry_t          ent,
  output logic            lt
);

  logic              valid_r;
  logic [DIST_W-1:0] dist_r;
  logic [ATOM_W-1:0] first_r;
  logic [ATOM_W-1:0] second_r;
  logic              v_eff;
  entry_t            ent_nxt;

  assign ent   = '{valid: valid_r, dist_sq: dist_r, first: first_r, second: second_r};
  assign v_eff = valid_r & in_range;
  assign lt    = !v_eff || (ctrl.dist_sq < dist_r);

  always_comb begin
    ent_nxt = ent;
    if (ctrl.flush) begin
      ent_nxt.valid = 1'b0;
    end else if (ctrl.insert) begin
      if (!ctrl.skip && lt) begin
        if (left_lt) begin
          ent_nxt       = left_ent;
          ent_nxt.valid = in_range & left_ent.valid;
        end else begin
          ent_nxt = '{valid: in_range, dist_sq: ctrl.dist_sq, first: ctrl.first,
                      second: ctrl.second};
        end
      end else begin
        ent_nxt.valid = v_eff;
      end
    end else if (ctrl.unload) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ent_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    dist_r   <= ent_nxt.dist_sq;
    first_r  <= ent_nxt.first;
    second_r <= ent_nxt.second;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/residue_pair_top_k_contacts_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// residue_pair_top_k_contacts_top: closest atom-pair contacts of a residue pair
// Distance stages in front of a row of compare-and-shift list cells.
//
// usage:
//   a request (one atom pair) is taken when start is high and busy is low.
//   each request passes through register, three squares, partial sums and
//   threshold checks, then one insert step in the cell row; busy stays high
//   from the register step until the insert step is done
//   a request with last_pair set then unloads the list from cell 0, one
//   contact per cycle: the first result follows the insert step,
//   the rest follow back to back, the farthest carries last_of_run.
//   busy stays high until the row is empty.
//   an abandoned residue pair or an empty list gives no result.
//   results are held on out_data for one cycle under out_strobe; the
//   receiver cannot stall them.
//   cfg_we writes threshold_sq, exclude_covalent or keep_count by cfg_idx;
//   write only while busy is low.
//   reset (rst_n low, synchronous) empties the list, clears the abandoned
//   flag and loads the register defaults.
// ----------------------------------------------------------------------------
module residue_pair_top_k_contacts_top import rptk_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_data,
  output logic                       out_strobe,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_INS  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [THR_W-1:0]  thr_r;
  logic              excl_r;
  logic [KEEP_W-1:0] keep_r;
  in_item_t          in_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r, sqz_r;
  logic [DIST_W-1:0] sum_r;
  logic              skip_r, hit_r;
  logic              abandoned_r, abandoned_nxt;
  logic              out_strobe_r;
  out_item_t         out_data_r;

  logic signed [COORD_W:0]   dx, dy, dz;
  logic signed [DIST_W-1:0]  px, py, pz;
  logic [DIST_W-1:0]         s1, s2, s3, thr34, far34;
  logic                      cov, e1, e2, e3, hit;
  logic                      drop_run;
  cell_ctrl_t                ctrl;
  entry_t                    ent [MAX_KEEP+1];
  logic                      lt [MAX_KEEP];
  logic [MAX_KEEP-1:0]       in_range;
  logic [MAX_KEEP-1:0]       vmask;

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RESET;
      excl_r <= 1'b0;
      keep_r <= KEEP_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_THRESHOLD_SQ:     thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_EXCLUDE_COVALENT: excl_r <= cfg_wdata[0];
        CFG_KEEP_COUNT:       keep_r <= cfg_wdata[KEEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // squares
  assign dx = $signed({in_r.second_x[COORD_W-1], in_r.second_x})
            - $signed({in_r.first_x[COORD_W-1], in_r.first_x});
  assign dy = $signed({in_r.second_y[COORD_W-1], in_r.second_y})
            - $signed({in_r.first_y[COORD_W-1], in_r.first_y});
  assign dz = $signed({in_r.second_z[COORD_W-1], in_r.second_z})
            - $signed({in_r.first_z[COORD_W-1], in_r.first_z});
  assign px = DIST_W'(dx) * DIST_W'(dx);
  assign py = DIST_W'(dy) * DIST_W'(dy);
  assign pz = DIST_W'(dz) * DIST_W'(dz);

  // partial sums and checks
  assign s1    = {2'b00, sqx_r};
  assign s2    = s1 + {2'b00, sqy_r};
  assign s3    = s2 + {2'b00, sqz_r};
  assign thr34 = {{(DIST_W-THR_W){1'b0}}, thr_r};
  assign far34 = {{(DIST_W-THR_W-4){1'b0}}, thr_r, 4'b0000};
  assign e1    = s1 > thr34;
  assign e2    = s2 > thr34;
  assign e3    = s3 > thr34;

  always_comb begin
    cov = 1'b0;
    if (excl_r && in_r.adjacent_residues) begin
      if (in_r.second_kind == KIND_N && (in_r.first_kind == KIND_CA ||
          in_r.first_kind == KIND_C || in_r.first_kind == KIND_O)) begin
        cov = 1'b1;
      end
      if (in_r.second_kind == KIND_CA && in_r.first_kind == KIND_C) begin
        cov = 1'b1;
      end
    end
    if (e1) begin
      hit = s1 > far34;
    end else if (e2) begin
      hit = s2 > far34;
    end else if (e3) begin
      hit = s3 > far34;
    end else begin
      hit = 1'b0;
    end
    hit = hit & !cov;
  end

  assign abandoned_nxt = abandoned_r | hit_r;
  assign drop_run      = in_r.last_pair & abandoned_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_INS;
      ST_INS: begin
        if (in_r.last_pair && !drop_run) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: if (!ent[0].valid) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      abandoned_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == ST_EMIT) && ent[0].valid;
      if (state_r == ST_INS) begin
        abandoned_r <= in_r.last_pair ? 1'b0 : abandoned_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      in_r <= in_data;
    end
    if (state_r == ST_SQ) begin
      sqx_r <= px[SQ_W-1:0];
      sqy_r <= py[SQ_W-1:0];
      sqz_r <= pz[SQ_W-1:0];
    end
    if (state_r == ST_SUM) begin
      sum_r  <= s3;
      skip_r <= cov | e3;
      hit_r  <= hit;
    end
    out_data_r <= '{out_first_atom: ent[0].first, out_second_atom: ent[0].second,
                    out_dist_sq: ent[0].dist_sq, last_of_run: !ent[1].valid};
  end

  // cell row
  assign ctrl = '{insert:  (state_r == ST_INS),
                  unload:  (state_r == ST_EMIT),
                  flush:   (state_r == ST_INS) && drop_run,
                  skip:    skip_r | abandoned_r,
                  dist_sq: sum_r,
                  first:   in_r.first_atom,
                  second:  in_r.second_atom};

  assign ent[MAX_KEEP] = '0;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    assign in_range[i] = (i == 0) || (32'(keep_r) > i);
    assign vmask[i]    = ent[i].valid;
    if (i == 0) begin : g_head
      rptk_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_range  (in_range[i]),
        .left_ent  ('0),
        .left_lt   (1'b0),
        .right_ent (ent[i+1]),
        .ent       (ent[i]),
        .lt        (lt[i])
      );
    end else begin : g_body
      rptk_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_range  (in_range[i]),
        .left_ent  (ent[i-1]),
        .left_lt   (lt[i-1]),
        .right_ent (ent[i+1]),
        .ent       (ent[i]),
        .lt        (lt[i])
      );
    end
  end

  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((vmask + MAX_KEEP'(1)) & vmask) == '0)
    else $error("kept entries not packed toward cell 0");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  a_strobe_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_EMIT))
    else $error("result outside unload phase");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last_of_run) |=> !out_strobe)
    else $error("result after last_of_run");

endmodule
`default_nettype wire

// ===== verif/contact_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contact_checker: result prediction and comparison for the contact selector
// Watches requests, register writes and results at the rising clock edge.
// Keeps its own sorted list of closest atom pairs per residue pair and
// compares every result, field by field, with the oldest expected contact.
// ----------------------------------------------------------------------------
module contact_checker import rptk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              in_data,
  input  logic                  out_strobe,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  localparam int PRINT_CAP = 40;

  logic [THR_W-1:0]  thr_sq;
  logic              skip_covalent;
  logic [KEEP_W-1:0] keep_reg;
  logic [DIST_W-1:0] near_dist [MAX_KEEP];
  logic [ATOM_W-1:0] near_first [MAX_KEEP];
  logic [ATOM_W-1:0] near_second [MAX_KEEP];
  int                near_count;
  logic              run_abandoned;
  out_item_t         expected_contacts [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) begin
      $display("%0t ns contact mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  task automatic insert_contact(input in_item_t req);
    longint    p [3];
    longint    q [3];
    longint    d;
    longint    sum;
    longint    thr;
    int        keep;
    int        pos;
    int        last_slot;
    bit        drop;
    out_item_t e;
    p[0] = $signed(req.first_x);
    p[1] = $signed(req.first_y);
    p[2] = $signed(req.first_z);
    q[0] = $signed(req.second_x);
    q[1] = $signed(req.second_y);
    q[2] = $signed(req.second_z);
    if (keep_reg == 0) begin
      keep = 1;
    end else if (keep_reg > MAX_KEEP) begin
      keep = MAX_KEEP;
    end else begin
      keep = int'(keep_reg);
    end
    if (near_count > keep) begin
      near_count = keep;
    end
    if (!run_abandoned) begin
      drop = 1'b0;
      // covalent backbone bonds across adjacent residues
      if (skip_covalent && req.adjacent_residues &&
          ((req.second_kind == KIND_N && (req.first_kind == KIND_CA ||
            req.first_kind == KIND_C || req.first_kind == KIND_O)) ||
           (req.second_kind == KIND_CA && req.first_kind == KIND_C))) begin
        drop = 1'b1;
      end
      thr = thr_sq;
      sum = 0;
      for (int axis = 0; axis < 3; axis++) begin
        if (!drop) begin
          d = q[axis] - p[axis];
          sum += d * d;
          if (sum > thr) begin
            if (sum > 16 * thr) begin
              run_abandoned = 1'b1;
            end
            drop = 1'b1;
          end
        end
      end
      if (!drop && (near_count < keep || sum < near_dist[near_count-1])) begin
        pos = 0;
        while (pos < near_count && !(sum < near_dist[pos])) begin
          pos++;
        end
        if (near_count < keep) begin
          last_slot = near_count;
          near_count++;
        end else begin
          last_slot = keep - 1;
        end
        for (int i = last_slot; i > pos; i--) begin
          near_dist[i] = near_dist[i-1];
          near_first[i] = near_first[i-1];
          near_second[i] = near_second[i-1];
        end
        near_dist[pos] = DIST_W'(sum);
        near_first[pos] = req.first_atom;
        near_second[pos] = req.second_atom;
      end
    end
    if (req.last_pair) begin
      if (!run_abandoned) begin
        for (int i = 0; i < near_count; i++) begin
          e.out_first_atom = near_first[i];
          e.out_second_atom = near_second[i];
          e.out_dist_sq = near_dist[i];
          e.last_of_run = (i == near_count - 1);
          expected_contacts.push_back(e);
        end
      end
      near_count = 0;
      run_abandoned = 1'b0;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t oldest;
    if (!rst_n) begin
      thr_sq = THRESHOLD_RESET;
      skip_covalent = 1'b0;
      keep_reg = KEEP_RESET;
      near_count = 0;
      run_abandoned = 1'b0;
      expected_contacts.delete();
    end else begin
      if (out_strobe) begin
        if (expected_contacts.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_data));
        end else begin
          oldest = expected_contacts.pop_front();
          if (out_data.out_first_atom !== oldest.out_first_atom) begin
            report_mismatch($sformatf("first atom got %0d want %0d",
                                      out_data.out_first_atom, oldest.out_first_atom));
          end
          if (out_data.out_second_atom !== oldest.out_second_atom) begin
            report_mismatch($sformatf("second atom got %0d want %0d",
                                      out_data.out_second_atom, oldest.out_second_atom));
          end
          if (out_data.out_dist_sq !== oldest.out_dist_sq) begin
            report_mismatch($sformatf("dist_sq got %0d want %0d",
                                      out_data.out_dist_sq, oldest.out_dist_sq));
          end
          if (out_data.last_of_run !== oldest.last_of_run) begin
            report_mismatch($sformatf("last_of_run got %b want %b",
                                      out_data.last_of_run, oldest.last_of_run));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_THRESHOLD_SQ: begin
            thr_sq = cfg_wdata[THR_W-1:0];
          end
          CFG_EXCLUDE_COVALENT: begin
            skip_covalent = cfg_wdata[0];
          end
          CFG_KEEP_COUNT: begin
            keep_reg = cfg_wdata[KEEP_W-1:0];
          end
          default: ;
        endcase
      end
      if (start && !busy) begin
        insert_contact(in_data);
      end
    end
    pending = expected_contacts.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the residue-pair contact selector
// Drives atom-pair requests and register writes: a directed list of boundary,
// covalent, tie, abandon and list-size cases, then random residue pairs under
// three sender idle profiles. Checking is done by the contact checker.
// ----------------------------------------------------------------------------
module tb_top;
  import rptk_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 140;

  localparam logic [KIND_W-1:0] KIND_OTHER     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SPARE     = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_TOP = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_data;
  logic                  out_strobe;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    idle_pct;
  int                    quiet_cycles = 0;

  always #(HALF_PERIOD) clk = ~clk;

  residue_pair_top_k_contacts_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  contact_checker u_contact_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // watchdog on cycles with no request and no result
  always @(posedge clk) begin
    if ((rst_n && start && busy === 1'b0) || out_strobe === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_item_t atom_pair(input int a1, input int a2,
                                         input int x1, input int y1, input int z1,
                                         input int x2, input int y2, input int z2,
                                         input bit adj, input logic [KIND_W-1:0] k1,
                                         input logic [KIND_W-1:0] k2, input bit last);
    in_item_t item;
    item.first_atom = ATOM_W'(a1);
    item.second_atom = ATOM_W'(a2);
    item.first_x = COORD_W'(x1);
    item.first_y = COORD_W'(y1);
    item.first_z = COORD_W'(z1);
    item.second_x = COORD_W'(x2);
    item.second_y = COORD_W'(y2);
    item.second_z = COORD_W'(z2);
    item.adjacent_residues = adj;
    item.first_kind = k1;
    item.second_kind = k2;
    item.last_pair = last;
    return item;
  endfunction

  function automatic in_item_t offset_pair(input int a1, input int a2, input int dx,
                                           input int dy, input int dz, input bit adj,
                                           input logic [KIND_W-1:0] k1,
                                           input logic [KIND_W-1:0] k2, input bit last);
    return atom_pair(a1, a2, 100, -200, 300, 100 + dx, -200 + dy, 300 + dz,
                     adj, k1, k2, last);
  endfunction

  task automatic send_pair(input in_item_t item);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // registers change only with the block idle and every result seen
  task automatic apply_settings(input int thr, input bit excl, input int keep);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    write_reg(CFG_THRESHOLD_SQ, thr);
    write_reg(CFG_EXCLUDE_COVALENT, 32'(excl));
    write_reg(CFG_KEEP_COUNT, keep);
  endtask

  task automatic random_settings();
    int thr;
    int keep;
    case ($urandom_range(9))
      0: thr = 0;
      1: thr = 16777215;
      default: thr = $urandom_range(5000, 3000000);
    endcase
    case ($urandom_range(7))
      0: keep = 0;
      1: keep = 15;
      2: keep = 1;
      3: keep = MAX_KEEP;
      default: keep = $urandom_range(1, MAX_KEEP);
    endcase
    apply_settings(thr, 1'($urandom_range(1)), keep);
  endtask

  task automatic random_residue_pair(input int count);
    int                reach;
    int                spread;
    int                roll;
    int                x1, y1, z1, x2, y2, z2;
    bit                adj;
    logic [KIND_W-1:0] k1, k2;
    case ($urandom_range(4))
      0: reach = 16;
      1: reach = 200;
      2: reach = 400;
      3: reach = 1500;
      default: reach = 4000;
    endcase
    adj = 1'($urandom_range(1));
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      // otherwise reuse the previous coordinates for an exact distance tie
      if (i == 0 || roll >= 6) begin
        x1 = $urandom_range(65535) - 32768;
        y1 = $urandom_range(65535) - 32768;
        z1 = $urandom_range(65535) - 32768;
        spread = (roll < 90) ? reach : 4 * reach;
        if (roll >= 98) begin
          x2 = $urandom_range(65535) - 32768;
          y2 = $urandom_range(65535) - 32768;
          z2 = $urandom_range(65535) - 32768;
        end else begin
          x2 = x1 + $urandom_range(2 * spread) - spread;
          y2 = y1 + $urandom_range(2 * spread) - spread;
          z2 = z1 + $urandom_range(2 * spread) - spread;
        end
      end
      if ($urandom_range(2) == 0) begin
        k1 = KIND_W'($urandom_range(KIND_N, KIND_O));
        k2 = KIND_W'($urandom_range(KIND_N, KIND_CA));
      end else begin
        k1 = KIND_W'($urandom_range(7));
        k2 = KIND_W'($urandom_range(7));
      end
      send_pair(atom_pair($urandom_range(65535), $urandom_range(65535),
                          x1, y1, z1, x2, y2, z2, adj, k1, k2, i == count - 1));
    end
  endtask

  initial begin
    int sent;
    int count;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
    idle_pct = 26;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    apply_settings(250000, 1'b1, MAX_KEEP);
    // boundary, covalent, unknown kinds, ties, coordinate extremes
    send_pair(offset_pair(0, 65535, 0, 0, 0, 1'b1, KIND_C, KIND_N, 1'b0));
    send_pair(offset_pair(1, 2, 500, 0, 0, 1'b1, KIND_CA, KIND_CA, 1'b0));
    send_pair(offset_pair(3, 4, 501, 0, 0, 1'b1, KIND_OTHER, KIND_N, 1'b0));
    send_pair(offset_pair(5, 6, -2000, 0, 0, 1'b0, KIND_O, KIND_O, 1'b0));
    send_pair(offset_pair(7, 8, 0, 0, 0, 1'b1, KIND_SPARE, KIND_SPARE_TOP, 1'b0));
    send_pair(offset_pair(9, 10, 0, 300, 0, 1'b1, KIND_N, KIND_C, 1'b0));
    send_pair(offset_pair(11, 12, 0, 0, -300, 1'b1, KIND_CA, KIND_O, 1'b0));
    send_pair(offset_pair(13, 14, 0, 0, 0, 1'b1, KIND_C, KIND_CA, 1'b0));
    send_pair(atom_pair(65535, 0, -32768, -32768, -32768, -32668, -32768, -32768,
                        1'b0, KIND_OTHER, KIND_OTHER, 1'b0));
    send_pair(atom_pair(16, 17, 32767, 32767, 32767, 32567, 32767, 32767,
                        1'b0, KIND_O, KIND_N, 1'b1));
    // abandoned residue pair
    send_pair(offset_pair(20, 21, 100, 0, 0, 1'b0, KIND_OTHER, KIND_OTHER, 1'b0));
    send_pair(offset_pair(22, 23, 2001, 0, 0, 1'b0, KIND_OTHER, KIND_OTHER, 1'b0));
    send_pair(offset_pair(24, 25, 0, 0, 0, 1'b0, KIND_OTHER, KIND_OTHER, 1'b0));
    send_pair(offset_pair(26, 27, 0, 0, 0, 1'b0, KIND_OTHER, KIND_OTHER, 1'b1));
    send_pair(atom_pair(30, 31, -32768, -32768, -32768, 32767, 32767, 32767,
                        1'b0, KIND_OTHER, KIND_OTHER, 1'b1));
    // empty list on the last request
    send_pair(offset_pair(32, 33, 0, 600, 0, 1'b0, KIND_OTHER, KIND_OTHER, 1'b1));
    // keep count lowered inside a residue pair
    send_pair(offset_pair(40, 41, 10, 0, 0, 1'b1, KIND_OTHER, KIND_OTHER, 1'b0));
    send_pair(offset_pair(42, 43, 20, 0, 0, 1'b1, KIND_OTHER, KIND_OTHER, 1'b0));
    send_pair(offset_pair(44, 45, 30, 0, 0, 1'b1, KIND_OTHER, KIND_OTHER, 1'b0));
    send_pair(offset_pair(46, 47, 40, 0, 0, 1'b1, KIND_OTHER, KIND_OTHER, 1'b0));
    apply_settings(250000, 1'b0, 2);
    send_pair(offset_pair(48, 49, 0, 5, 0, 1'b1, KIND_O, KIND_N, 1'b1));
    // zero threshold, keep count above the row size
    apply_settings(0, 1'b1, 15);
    send_pair(offset_pair(50, 51, 0, 0, 0, 1'b0, KIND_OTHER, KIND_OTHER, 1'b0));
    send_pair(offset_pair(52, 53, 0, 0, 0, 1'b0, KIND_OTHER, KIND_OTHER, 1'b1));
    // full threshold, keep count of zero
    apply_settings(16777215, 1'b0, 0);
    send_pair(offset_pair(54, 55, 4096, 0, 0, 1'b0, KIND_OTHER, KIND_OTHER, 1'b0));
    send_pair(offset_pair(56, 57, 0, -4095, 0, 1'b0, KIND_OTHER, KIND_OTHER, 1'b1));

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 26 : ((ph == 1) ? 61 : 0);
      random_settings();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        count = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
        random_residue_pair(count);
        sent += count;
        if ($urandom_range(11) == 0) begin
          random_settings();
        end
      end
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rptk_pkg.sv
hw/rtl/rptk_cell.sv
hw/rtl/residue_pair_top_k_contacts_top.sv
verif/contact_checker.sv
verif/tb_top.sv
